// ===== rtl/tmvg_pkg.sv =====
// ----------------------------------------------------------------------------
// tmvg_pkg
// Shared types and constants for the torus mesh vertex generator.
// ----------------------------------------------------------------------------
package tmvg_pkg;

  localparam int RadW  = 30;
  localparam int CntW  = 11;
  localparam int IdxW  = 10;
  localparam int PosW  = 40;
  localparam int IdW   = 20;

  // Cells in the chain: 32 division, 7 sine, 2 scaling
  localparam int NCell = 41;

  // Polynomial coefficients, Q30
  localparam logic [31:0] A1 = 32'd1686629713;
  localparam logic [31:0] A3 = 32'd693598668;
  localparam logic [31:0] A5 = 32'd85569306;
  localparam logic [31:0] A7 = 32'd5026995;
  localparam logic [31:0] A9 = 32'd172272;

  localparam logic [1:0] REG_MAJOR = 2'd0;
  localparam logic [1:0] REG_MINOR = 2'd1;
  localparam logic [1:0] REG_RINGS = 2'd2;
  localparam logic [1:0] REG_SEGS  = 2'd3;

  // Payload that travels down the cell chain
  typedef struct packed {
    logic        vld;
    logic        err;
    logic [IdxW-1:0] ii;
    logic [IdxW-1:0] jj;
    logic [31:0] phi;       // ring phase
    logic [31:0] th;        // segment phase
    // four sine evaluations: 0 cos phi, 1 sin phi, 2 cos theta, 3 sin theta
    logic [3:0][30:0] x;    // quarter fraction, 0..2^30
    logic [3:0]       neg;
    logic [3:0][31:0] x2;
    logic [3:0][31:0] p;
    logic [3:0][31:0] s;    // signed Q30 result
    logic [IdW-1:0] vid;
    logic [IdW-1:0] cnr;
    logic [IdW-1:0] cdg;
    logic [IdW-1:0] cns;
    logic [63:0] t;         // signed intermediate
    logic [PosW-1:0] px;
    logic [PosW-1:0] py;
    logic [PosW-1:0] pz;
  } tmvg_item_t;

  // Rounded v/2^30, halves away from zero
  function automatic logic [63:0] round30(input logic signed [95:0] v);
    logic [95:0] m;
    begin
      m = v[95] ? (96'(-v) + (96'd1 << 29)) >> 30 : (96'(v) + (96'd1 << 29)) >> 30;
      round30 = v[95] ? 64'(-m) : m[63:0];
    end
  endfunction

endpackage

// ===== rtl/tmvg_cell.sv =====
// ----------------------------------------------------------------------------
// tmvg_cell
// One stage of the vertex chain; STEP selects the work done here.
// ----------------------------------------------------------------------------
module tmvg_cell
  import tmvg_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [RadW-1:0]  rad_major,
  input  logic [RadW-1:0]  rad_tube,
  input  logic [CntW-1:0]  nr,
  input  logic [CntW-1:0]  ns,
  input  tmvg_item_t       d_in,
  output tmvg_item_t       d_out
);

  tmvg_item_t d_r, d_nxt;
  assign d_out = d_r;

  // STEP 0..31: phase division, one quotient bit of phi and of theta each,
  // restoring division of k*2^32 by count; remainders kept in t.
  always_comb begin
    logic [63:0] a, b;
    logic [31:0] ph;
    logic signed [95:0] prod;
    d_nxt = d_in;
    a = '0; b = '0; ph = '0; prod = '0;
    if (STEP < 32) begin
      // phi remainder in t[31:0], theta remainder in t[63:32]
      a = 64'({d_in.t[31:0], 1'b0});
      b = 64'({d_in.t[63:32], 1'b0});
      if (a[32:0] >= 33'(nr)) begin
        a = a - 64'(nr); ph = d_in.phi | (32'd1 << (31 - STEP));
      end else ph = d_in.phi;
      d_nxt.phi = ph;
      d_nxt.t[31:0] = a[31:0];
      if (b[32:0] >= 33'(ns)) begin
        b = b - 64'(ns); d_nxt.th = d_in.th | (32'd1 << (31 - STEP));
      end
      d_nxt.t[63:32] = b[31:0];
    end else if (STEP == 32) begin
      for (int k = 0; k < 4; k++) begin
        ph = (k == 0) ? d_in.phi + 32'h4000_0000 : (k == 1) ? d_in.phi :
             (k == 2) ? d_in.th + 32'h4000_0000 : d_in.th;
        d_nxt.neg[k] = ph[31];
        d_nxt.x[k] = ph[30] ? 31'h4000_0000 - 31'(ph[29:0]) : 31'(ph[29:0]);
      end
    end else if (STEP == 33) begin
      for (int k = 0; k < 4; k++) begin
        d_nxt.x2[k] = 32'((64'(d_in.x[k]) * 64'(d_in.x[k])) >> 30);
        d_nxt.p[k] = A9;
      end
    end else if (STEP >= 34 && STEP <= 37) begin
      for (int k = 0; k < 4; k++) begin
        ph = (STEP == 34) ? A7 : (STEP == 35) ? A5 : (STEP == 36) ? A3 : A1;
        d_nxt.p[k] = ph - 32'((64'(d_in.x2[k]) * 64'(d_in.p[k])) >> 30);
      end
    end else if (STEP == 38) begin
      for (int k = 0; k < 4; k++) begin
        a = (64'(d_in.x[k]) * 64'(d_in.p[k])) >> 30;
        if (a > 64'h4000_0000) a = 64'h4000_0000;
        d_nxt.s[k] = d_in.neg[k] ? 32'(-a) : a[31:0];
      end
    end else if (STEP == 39) begin
      prod = 96'({2'b0, rad_major} + {2'b0, rad_tube}) * 96'sh4000_0000
           - 96'($signed(d_in.s[2])) * 96'(rad_tube);
      d_nxt.t = round30(prod);
      d_nxt.py = PosW'(round30(96'($signed(d_in.s[3])) * 96'(rad_tube)));
    end else begin
      // t is never negative and stays below 2^32
      d_nxt.px = PosW'(round30(96'($signed(d_in.s[0])) * 96'($signed(d_in.t[32:0]))));
      d_nxt.pz = PosW'(round30(96'($signed(d_in.s[1])) * 96'($signed(d_in.t[32:0]))));
      if (d_in.err) begin
        d_nxt.px = '0; d_nxt.py = '0; d_nxt.pz = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== rtl/torus_mesh_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// torus_mesh_vertex_generator
// Torus tessellation: grid position in, vertex position and quad indices out.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)
// in_     | in  | ring_index[9:0], segment_index[19:10]
// out_    | out | pos_x, pos_y, pos_z, vertex_id, corner_next_ring,
//         |     | corner_diagonal, corner_next_segment (200 bits)
//         |     | tuser: index_error
// cfg_    | in  | cfg_index selects register, cfg_data value
//
// One word per cycle sustained. The chain holds 32 cells of phase
// division (one quotient bit each), seven of sine polynomial, two of scaling.
// The whole chain advances together; out_tvalid low or out_tready high lets it
// move. Synchronous active-low reset clears valid bits and restores registers.
module torus_mesh_vertex_generator
  import tmvg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // ring_index, segment_index
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // pos_x, pos_y, pos_z, vertex_id, corners
  output logic         out_tuser,  // index_error
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [RadW-1:0] major_r, minor_r;
  logic [CntW-1:0] rings_r, segs_r, nr, ns;
  tmvg_item_t chain [NCell+1];
  tmvg_item_t head;
  logic en;
  logic [IdxW-1:0] ri, sj;
  logic [IdW-1:0] ns20;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r <= RadW'(65536); minor_r <= RadW'(16384);
      rings_r <= CntW'(16); segs_r <= CntW'(16);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAJOR: major_r <= cfg_data[RadW-1:0];
        REG_MINOR: minor_r <= cfg_data[RadW-1:0];
        REG_RINGS: rings_r <= cfg_data[CntW-1:0];
        REG_SEGS:  segs_r  <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts to the grid maximum
  assign nr = (rings_r > CntW'(1024)) ? CntW'(1024) : rings_r;
  assign ns = (segs_r > CntW'(1024)) ? CntW'(1024) : segs_r;

  assign en = !chain[NCell].vld || out_tready;
  assign in_tready = en;

  assign ri = in_tdata[9:0];
  assign sj = in_tdata[19:10];
  assign ns20 = IdW'(ns);

  // Entry: index checks, wrap, linear ids; division remainders start at k
  always_comb begin
    head = '0;
    head.vld = in_tvalid;
    head.err = ({1'b0, ri} >= nr) || ({1'b0, sj} >= ns);
    head.ii = (11'(ri) + 11'd1 == nr) ? '0 : ri + 10'd1;
    head.jj = (11'(sj) + 11'd1 == ns) ? '0 : sj + 10'd1;
    head.vid = IdW'(ri * ns20 + IdW'(sj));
    head.cnr = IdW'(head.ii * ns20 + IdW'(sj));
    head.cdg = IdW'(head.ii * ns20 + IdW'(head.jj));
    head.cns = IdW'(ri * ns20 + IdW'(head.jj));
    head.t = {22'd0, sj, 22'd0, ri};
    if (head.err) begin
      head.vid = '0; head.cnr = '0; head.cdg = '0; head.cns = '0;
      head.t = '0;
    end
  end
  assign chain[0] = head;

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    tmvg_cell #(.STEP(g)) u_cell (
      .clk, .rst_n, .en,
      .rad_major(major_r), .rad_tube(minor_r), .nr, .ns,
      .d_in(chain[g]), .d_out(chain[g+1])
    );
  end

  assign out_tvalid = chain[NCell].vld;
  assign out_tuser  = chain[NCell].err;
  assign out_tdata  = {chain[NCell].cns, chain[NCell].cdg, chain[NCell].cnr,
                       chain[NCell].vid, chain[NCell].pz, chain[NCell].py,
                       chain[NCell].px};

endmodule

// ===== rtl/tmvg_check.sv =====
// ----------------------------------------------------------------------------
// tmvg_check
// Port-level checks for the torus mesh vertex generator.
// ----------------------------------------------------------------------------
module tmvg_check (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata,
  input logic         out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("data moved");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0) else $error("error word not zero");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("stalled while output empty");
endmodule

bind torus_mesh_vertex_generator tmvg_check u_tmvg_check (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives grid positions into the torus vertex generator under random bursts
// and output stalls, predicts each vertex and quad with an independent
// fixed-point model, and compares every result word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import tmvg_pkg::*;

  localparam int MaxGrid  = 1024;
  localparam int Latency  = 41;
  localparam int CycLimit = 600000;

  // Expected vertex word
  typedef struct {
    logic [39:0] px, py, pz;
    logic [19:0] vid, cnr, cdg, cns;
    logic        err;
  } vertex_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;    // ring_index[9:0], segment_index[19:10]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [199:0] out_tdata;        // px, py, pz, vid, cnr, cdg, cns
  logic         out_tuser;        // index_error
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // Shadow copy of the block's registers
  logic [29:0] major_r, minor_r;
  logic [10:0] rings, segs;

  vertex_t pending_vertices[$];
  int      n_fail = 0;
  int      cycles = 0;
  int      burst_left = 0;
  int      stall_mode = 0;

  torus_mesh_vertex_generator DUT (.*);

  always #6 clk = ~clk;

  // ---- fixed-point trig: Q30 sine of a 32-bit turn fraction ----
  function automatic longint sin_q30(input logic [31:0] ph);
    logic [63:0] x, x2, p, r;
    begin
      x = ph[30] ? (64'h4000_0000 - ph[29:0]) : {34'd0, ph[29:0]};
      x2 = (x * x) >> 30;
      p = 64'(A9);
      p = 64'(A7) - ((x2 * p) >> 30);
      p = 64'(A5) - ((x2 * p) >> 30);
      p = 64'(A3) - ((x2 * p) >> 30);
      p = 64'(A1) - ((x2 * p) >> 30);
      r = (x * p) >> 30;
      if (r > 64'h4000_0000) r = 64'h4000_0000;
      sin_q30 = ph[31] ? -longint'(r) : longint'(r);
    end
  endfunction

  // round v / 2^30, halves away from zero (v fits 128 bits easily)
  function automatic longint rnd30(input logic signed [127:0] v);
    logic [127:0] m;
    begin
      m = v[127] ? ((-v) + (128'd1 << 29)) >> 30 : (v + (128'd1 << 29)) >> 30;
      rnd30 = v[127] ? -longint'(m[63:0]) : longint'(m[63:0]);
    end
  endfunction

  function automatic vertex_t torus_vertex(input logic [9:0] i, input logic [9:0] j);
    vertex_t v;
    longint nr, ns, ii, jj, cphi, sphi, cth, sth, t;
    logic [63:0] phi, th;
    logic signed [127:0] acc;
    begin
      v = '{default: '0};
      nr = (rings > MaxGrid) ? MaxGrid : rings;
      ns = (segs > MaxGrid) ? MaxGrid : segs;
      if (i >= nr || j >= ns) begin
        v.err = 1'b1;
        return v;
      end
      phi = (64'(i) << 32) / nr;
      th = (64'(j) << 32) / ns;
      cphi = sin_q30(phi[31:0] + 32'h4000_0000);
      sphi = sin_q30(phi[31:0]);
      cth = sin_q30(th[31:0] + 32'h4000_0000);
      sth = sin_q30(th[31:0]);
      acc = 128'(longint'(major_r) + longint'(minor_r)) * 128'sd1073741824
            - 128'(cth) * 128'(longint'(minor_r));
      t = rnd30(acc);
      v.px = 40'(rnd30(128'(cphi) * 128'(t)));
      v.py = 40'(rnd30(128'(sth) * 128'(longint'(minor_r))));
      v.pz = 40'(rnd30(128'(sphi) * 128'(t)));
      ii = (i + 1 == nr) ? 0 : i + 1;
      jj = (j + 1 == ns) ? 0 : j + 1;
      v.vid = 20'(i * ns + j);
      v.cnr = 20'(ii * ns + j);
      v.cdg = 20'(ii * ns + jj);
      v.cns = 20'(i * ns + jj);
      return v;
    end
  endfunction

  // ---- result checker; receiver stall pattern is re-chosen at random ----
  always @(posedge clk) begin
    vertex_t e;
    cycles <= cycles + 1;
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= (cycles % 7 < 2);
    endcase
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected result word");
        n_fail++;
      end else begin
        e = pending_vertices.pop_front();
        if (out_tdata[39:0] !== e.px) begin
          $error("pos_x exp %h got %h", e.px, out_tdata[39:0]); n_fail++;
        end
        if (out_tdata[79:40] !== e.py) begin
          $error("pos_y exp %h got %h", e.py, out_tdata[79:40]); n_fail++;
        end
        if (out_tdata[119:80] !== e.pz) begin
          $error("pos_z exp %h got %h", e.pz, out_tdata[119:80]); n_fail++;
        end
        if (out_tdata[139:120] !== e.vid) begin
          $error("vertex_id exp %0d got %0d", e.vid, out_tdata[139:120]);
          n_fail++;
        end
        if (out_tdata[159:140] !== e.cnr) begin
          $error("corner_next_ring exp %0d got %0d", e.cnr, out_tdata[159:140]);
          n_fail++;
        end
        if (out_tdata[179:160] !== e.cdg) begin
          $error("corner_diagonal exp %0d got %0d", e.cdg, out_tdata[179:160]);
          n_fail++;
        end
        if (out_tdata[199:180] !== e.cns) begin
          $error("corner_next_segment exp %0d got %0d", e.cns, out_tdata[199:180]);
          n_fail++;
        end
        if (out_tuser !== e.err) begin
          $error("index_error exp %b got %b", e.err, out_tuser); n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CycLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---- one grid position; sender bursts with random gaps ----
  task automatic send_position(input logic [9:0] i, input logic [9:0] j);
    int gap;
    begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_tvalid <= 1'b1;
      in_tdata <= {4'd0, j, i};
      do @(posedge clk); while (!in_tready);
      pending_vertices.push_back(torus_vertex(i, j));
    end
  endtask

  // drain, then register write while idle
  task automatic wait_idle();
    begin
      in_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clk);
      repeat (Latency + 4) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      case (idx)
        REG_MAJOR: major_r = val[29:0];
        REG_MINOR: minor_r = val[29:0];
        REG_RINGS: rings = val[10:0];
        default:   segs = val[10:0];
      endcase
    end
  endtask

  task automatic set_torus(input logic [31:0] maj, input logic [31:0] mnr,
                           input logic [31:0] nr, input logic [31:0] ns);
    begin
      wait_idle();
      write_reg(REG_MAJOR, maj);
      write_reg(REG_MINOR, mnr);
      write_reg(REG_RINGS, nr);
      write_reg(REG_SEGS, ns);
    end
  endtask

  // corners, wrap and out-of-range positions at reset setting
  task automatic test_directed_reset_setting();
    begin
      send_position(0, 0);
      send_position(15, 15);
      send_position(4, 4);
      send_position(8, 12);
      send_position(16, 0);
      send_position(0, 16);
      send_position(10'h3FF, 10'h3FF);
      send_position(10'h2AA, 10'h155);
    end
  endtask

  // extreme radii and counts, zero count, count above the grid limit
  task automatic test_extreme_settings();
    begin
      set_torus(32'h3FFF_FFFF, 32'h3FFF_FFFF, 1024, 1024);
      send_position(0, 0);
      send_position(1023, 1023);
      send_position(511, 256);
      set_torus(0, 0, 1, 1);
      send_position(0, 0);
      send_position(1, 0);
      set_torus(32'hFFFF_FFFF, 0, 0, 3);
      send_position(0, 0);
      set_torus(100, 32'h3FFF_FFFF, 2047, 1500);
      send_position(1023, 1023);
      send_position(0, 512);
    end
  endtask

  // random settings; mostly in-range positions, some out of range
  task automatic test_random_positions();
    logic [9:0] i, j;
    begin
      for (int ph = 0; ph < 7; ph++) begin
        set_torus($urandom, $urandom, $urandom_range(1, 40), $urandom_range(1, 40));
        if (ph == 6) begin
          write_reg(REG_RINGS, $urandom_range(1000, 2047));
          write_reg(REG_SEGS, $urandom_range(1000, 2047));
        end
        for (int n = 0; n < 250; n++) begin
          if ($urandom_range(0, 9) != 0) begin
            i = 10'($urandom_range(0, (rings > MaxGrid ? MaxGrid : rings) - 1));
            j = 10'($urandom_range(0, (segs > MaxGrid ? MaxGrid : segs) - 1));
          end else begin
            i = 10'($urandom);
            j = 10'($urandom);
          end
          send_position(i, j);
        end
      end
    end
  endtask

  initial begin
    major_r = 30'd65536;
    minor_r = 30'd16384;
    rings = 11'd16;
    segs = 11'd16;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_reset_setting();
    test_extreme_settings();
    test_random_positions();
    wait_idle();
    if (n_fail == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tmvg_pkg.sv
rtl/tmvg_cell.sv
rtl/torus_mesh_vertex_generator.sv
rtl/tmvg_check.sv
bench/testbench.sv
